// File: src/sha256_stream_hasher_unit_assert.svh
// Assertion macros for the checker file of the hasher.
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: src/sha_pkg.sv
// Package of the hasher: types, constants and round functions.
package sha_pkg;
  localparam int unsigned RoundCount = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       count_byte;
    logic       start_comp;
    logic       round_step;
    logic       finish_comp;
    logic       reset_chain;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
    logic [7:0] len_byte_0;
  } dp_stat_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  localparam logic [7:0] PadByte = 8'h80;
endpackage

// File: src/sha_if.sv
// Valid/ready stream interfaces for input bytes and digest words.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, data_byte, has_byte, last, input ready);
  modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: src/sha_datapath.sv
// Datapath of the hasher: block words, length, schedule and round unit.
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::dp_cmd_t  cmd,
  output sha_pkg::dp_stat_t stat,
  input  logic [1:0]        out_sel,
  output logic [63:0]       out_word
);
  import sha_pkg::*;

  logic [5:0]  fill;
  logic [60:0] byte_total;
  word_t       chain [8];
  word_t       wv [8];
  word_t       sched [16];
  logic [5:0]  round;
  logic [63:0] bits;
  logic [7:0]  len_byte;
  word_t       w, s0, s1, t1, t2, w15, w2;
  logic [3:0]  ri;

  assign bits = {byte_total, 3'b000};
  // Length byte for the fill position 56..63, big-endian.
  assign len_byte = bits[8'(63 - 8 * int'(fill[2:0])) -: 8];

  always_comb begin
    ri  = round[3:0];
    w15 = sched[4'(ri + 4'd1)];
    w2  = sched[4'(ri + 4'd14)];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    w   = (round < 6'd16) ? sched[ri] : sched[ri] + s0 + sched[4'(ri + 4'd9)] + s1;
    t1  = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25)) +
          ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_k(round) + w;
    t2  = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22)) +
          ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Bytes land big-endian straight in the schedule words, which double as
  // the block buffer; every byte of a block is rewritten before it compresses.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      sched[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cmd.byte_val;
    end
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round_step) begin
      sched[ri] <= w;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_chain) begin
      fill <= '0;
      byte_total <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_h(3'(i));
      end
    end else begin
      if (cmd.load_byte) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_byte) begin
        byte_total <= byte_total + 61'd1;
      end
      if (cmd.start_comp) begin
        round <= '0;
      end else if (cmd.round_step) begin
        round <= round + 6'd1;
      end
      if (cmd.finish_comp) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end
    end
  end

  assign out_word        = {chain[{out_sel, 1'b0}], chain[{out_sel, 1'b1}]};
  assign stat.fill       = fill;
  assign stat.round      = round;
  assign stat.len_byte_0 = len_byte;
endmodule

// File: src/sha_ctrl.sv
// Controller of the hasher: sequences bytes, padding, rounds and output.
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  sha_in_if.sink            in_ch,
  sha_out_if.source         out_ch,
  output sha_pkg::dp_cmd_t  cmd,
  input  sha_pkg::dp_stat_t stat,
  output logic [1:0]        out_sel,
  input  logic [63:0]       out_word
);
  import sha_pkg::*;

  localparam logic [2:0] StIdle = 3'd0, StComp = 3'd1, StPad = 3'd2, StZero = 3'd3,
                         StLen = 3'd4, StOut = 3'd5, StStart = 3'd6, StFin = 3'd7;

  logic [2:0] state, state_next;
  logic       final_pass, final_next;
  logic [1:0] idx, idx_next;
  logic       pad_done, pad_done_next;
  logic       pad_sent, pad_sent_next;

  assign in_ch.ready        = (state == StIdle);
  assign out_ch.valid       = (state == StOut);
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 2'd3);
  assign out_sel            = idx;

  always_comb begin
    cmd = '0;
    state_next = state;
    final_next = final_pass;
    idx_next = idx;
    pad_done_next = pad_done;
    pad_sent_next = pad_sent;
    unique case (state)
      StIdle: begin
        if (in_ch.valid) begin
          cmd.load_byte = in_ch.has_byte;
          cmd.byte_val = in_ch.data_byte;
          cmd.count_byte = in_ch.has_byte;
          final_next = in_ch.last;
          pad_done_next = 1'b0;
          pad_sent_next = 1'b0;
          if (in_ch.has_byte && stat.fill == 6'd63) begin
            state_next = StStart;
          end else if (in_ch.last) begin
            state_next = StPad;
          end
        end
      end
      StStart: begin
        cmd.start_comp = 1'b1;
        state_next = StComp;
      end
      StComp: begin
        cmd.round_step = 1'b1;
        if (stat.round == 6'd63) begin
          state_next = StFin;
        end
      end
      StFin: begin
        cmd.finish_comp = 1'b1;
        if (!final_pass) begin
          state_next = StIdle;
        end else if (pad_done) begin
          idx_next = 2'd0;
          state_next = StOut;
        end else if (!pad_sent) begin
          state_next = StPad;
        end else begin
          state_next = StZero;
        end
      end
      StPad: begin
        cmd.load_byte = 1'b1;
        cmd.byte_val = PadByte;
        pad_done_next = 1'b0;
        pad_sent_next = 1'b1;
        state_next = (stat.fill == 6'd63) ? StStart : StZero;
      end
      StZero: begin
        if (stat.fill == 6'd56) begin
          state_next = StLen;
        end else begin
          cmd.load_byte = 1'b1;
          cmd.byte_val = 8'h00;
          if (stat.fill == 6'd63) begin
            state_next = StStart;
          end
        end
      end
      StLen: begin
        cmd.load_byte = 1'b1;
        cmd.byte_val = stat.len_byte_0;
        if (stat.fill == 6'd63) begin
          pad_done_next = 1'b1;
          state_next = StStart;
        end
      end
      StOut: begin
        if (out_ch.ready) begin
          idx_next = idx + 2'd1;
          if (idx == 2'd3) begin
            cmd.reset_chain = 1'b1;
            final_next = 1'b0;
            state_next = StIdle;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      final_pass <= 1'b0;
      idx <= '0;
      pad_done <= 1'b0;
      pad_sent <= 1'b0;
    end else begin
      state <= state_next;
      final_pass <= final_next;
      idx <= idx_next;
      pad_done <= pad_done_next;
      pad_sent <= pad_sent_next;
    end
  end
endmodule

// File: src/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 byte-stream hasher.
//
// Channel  Dir  Payload                               Beat
// in_ch    in   data_byte[7:0], has_byte, last        one message byte / end mark
// out_ch   out  digest_word[63:0], word_index, last_word  one 64-bit digest word
//
// The 64th byte of a block is followed by a compression (one load, 64 rounds
// at one a cycle, one fold into the chain). A last beat adds the padding
// bytes at one a cycle, a turn-around step at byte 56, and one or two
// compressions, then four digest beats.
// Reset sets the chaining words to the standard initial values and clears counts.
// A stalled digest word holds until taken; no byte is accepted meanwhile.
module sha256_stream_hasher_unit (
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [1:0]  out_sel;
  logic [63:0] out_word;

  // Controller owns the handshakes; the datapath only acts on commands.
  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cmd(cmd), .stat(stat), .out_sel(out_sel), .out_word(out_word)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .out_sel(out_sel), .out_word(out_word)
  );
endmodule

// File: src/sha_checker.sv
// Port-level checker for the hasher, bound to the top level.
`include "sha256_stream_hasher_unit_assert.svh"
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);
  `SHA_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  `SHA_ASSERT_IMP(a_last_flag, clk, rst, out_valid, last_word == (word_index == 2'd3))
  `SHA_ASSERT_NEXT(a_index_step, clk, rst, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 2'd1)
  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(digest_word))
endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .digest_word(out_ch.digest_word),
  .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);
